### hw/rtl/smpr_pkg.sv
`default_nettype none

package smpr_pkg;

    localparam int CHANNELS_DEFAULT = 2;

    localparam int KIND_W   = 2;
    localparam int DUTY_W   = 7;
    localparam int DIR_W    = 2;
    localparam int TICKS_W  = 15;
    localparam int STEP_W   = 11;
    localparam int CMP_W    = 10;
    localparam int TOL_W    = 7;
    localparam int PINS_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam int PROD_W   = 20;
    localparam int SQ_W     = 40;
    localparam int CUBE_W   = 60;
    localparam int QUOT_W   = 10;
    localparam int ODD_W    = 35;
    localparam int ODD_SHIFT = 15;

    localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PERIOD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd2;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;

    localparam logic [PINS_W-1:0] PINS_OFF = 2'b00;
    localparam logic [PINS_W-1:0] PINS_CW  = 2'b01;
    localparam logic [PINS_W-1:0] PINS_CCW = 2'b10;

    localparam logic [CFG_IDX_W-1:0] REG_DECEL_LEAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOL = 1'd1;

    localparam logic [TICKS_W-1:0] DECEL_LEAD_RESET = 15'd1000;
    localparam logic [TOL_W-1:0]   SETTLE_TOL_RESET = 7'd10;

    localparam logic [STEP_W-1:0] STEP_FULL = 11'd2000;
    localparam logic [STEP_W-1:0] STEP_HALF = 11'd1000;
    localparam logic [STEP_W-1:0] STEP_IDLE = 11'd54;
    localparam logic [STEP_W-1:0] STEP_LAST = 11'd1946;

    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
    localparam logic [CMP_W-1:0]  DUTY_SCALE = 10'd10;

    // 2^60 / 10^15 rounded down. The top 20 cube bits times this value, shifted right
    // by 20, fall short of the quotient by less than one.
    localparam logic [PROD_W-1:0] PROFILE_RECIP = 20'd1152;
    // 10^15 is 2^15 times this odd factor.
    localparam logic [ODD_W-1:0]  PROFILE_ODD = 35'd30517578125;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RAMP,
        ST_MUL_P,
        ST_MUL_SQ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_EST,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_FINISH,
        ST_OUT
    } smpr_state_t;

endpackage

`default_nettype wire

### hw/rtl/smpr_req_if.sv
`default_nettype none

interface smpr_req_if;
    logic                          valid;
    logic                          ready;
    logic [smpr_pkg::KIND_W-1:0]   kind;
    logic                          channel;
    logic [smpr_pkg::DUTY_W-1:0]   duty_percent;
    logic [smpr_pkg::DIR_W-1:0]    direction;
    logic [smpr_pkg::TICKS_W-1:0]  time_ms;

    modport source (
        output valid, kind, channel, duty_percent, direction, time_ms,
        input  ready
    );

    modport sink (
        input  valid, kind, channel, duty_percent, direction, time_ms,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/smpr_res_if.sv
`default_nettype none

interface smpr_res_if;
    logic                        valid;
    logic                        ready;
    logic                        out_channel;
    logic [smpr_pkg::CMP_W-1:0]  compare_value;
    logic                        drive_a;
    logic                        drive_b;
    logic                        pwm_enable;
    logic                        ramp_running;

    modport source (
        output valid, out_channel, compare_value, drive_a, drive_b, pwm_enable,
               ramp_running,
        input  ready
    );

    modport sink (
        input  valid, out_channel, compare_value, drive_a, drive_b, pwm_enable,
               ramp_running,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/s_curve_motor_pwm_ramp_top.sv
// A request runs EXEC, then OUT; a ramp update without a profile step adds RAMP, and one
// that computes a step goes on from RAMP through 4 passes of one 20x20 multiplier for the
// cube, then 3 more that estimate and check the quotient by 10^15, and then FINISH.
// A new request is taken only after the result is accepted; ready is high only in idle.
// Reset (rst_n, asynchronous, active low) sets every channel to step 54, all other channel
// state zero, and the registers to a lead of 1000 ticks and a tolerance of 10.
`default_nettype none

module s_curve_motor_pwm_ramp_top #(
    parameter int CHANNELS = smpr_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [smpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    smpr_req_if.sink                               req,
    smpr_res_if.source                             res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    smpr_pkg::smpr_state_t state_reg, state_next;

    logic [smpr_pkg::TICKS_W-1:0] decel_lead_reg;
    logic [smpr_pkg::TOL_W-1:0]   settle_tol_reg;

    logic [smpr_pkg::STEP_W-1:0]  phase_step_reg [CHANNELS];
    logic [smpr_pkg::STEP_W-1:0]  phase_step_next [CHANNELS];
    logic [smpr_pkg::CMP_W-1:0]   current_cmp_reg [CHANNELS];
    logic [smpr_pkg::CMP_W-1:0]   current_cmp_next [CHANNELS];
    logic [smpr_pkg::CMP_W-1:0]   target_cmp_reg [CHANNELS];
    logic [smpr_pkg::CMP_W-1:0]   target_cmp_next [CHANNELS];
    logic [smpr_pkg::TICKS_W-1:0] remaining_reg [CHANNELS];
    logic [smpr_pkg::TICKS_W-1:0] remaining_next [CHANNELS];
    logic [smpr_pkg::PINS_W-1:0]  pins_reg [CHANNELS];
    logic [smpr_pkg::PINS_W-1:0]  pins_next [CHANNELS];
    logic                         output_on_reg [CHANNELS];
    logic                         output_on_next [CHANNELS];
    logic                         ramp_on_reg [CHANNELS];
    logic                         ramp_on_next [CHANNELS];

    logic [smpr_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic                         ch_reg, ch_next;
    logic [smpr_pkg::DUTY_W-1:0]  duty_reg, duty_next;
    logic [smpr_pkg::DIR_W-1:0]   dir_reg, dir_next;
    logic [smpr_pkg::TICKS_W-1:0] tms_reg, tms_next;

    logic [smpr_pkg::STEP_W-1:0]  kn_reg, kn_next;
    logic [smpr_pkg::PROD_W-1:0]  p_reg, p_next;
    logic [smpr_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [smpr_pkg::CUBE_W-1:0]  acc_reg, acc_next;
    logic [smpr_pkg::CUBE_W-1:0]  div_reg, div_next;
    logic [smpr_pkg::QUOT_W-1:0]  q_reg, q_next;

    logic [smpr_pkg::PROD_W-1:0]  mul_a, mul_b;
    logic [smpr_pkg::SQ_W-1:0]    mul_prod;

    logic [CH_W-1:0]              ch_idx;
    logic                         ch_ok;
    logic [smpr_pkg::STEP_W-1:0]  k_cur;
    logic [smpr_pkg::STEP_W-1:0]  k_inc;
    logic [smpr_pkg::STEP_W-1:0]  k_mir;
    logic [smpr_pkg::CMP_W-1:0]   cur_cur;
    logic [smpr_pkg::CMP_W-1:0]   tgt_cur;
    logic [smpr_pkg::TICKS_W-1:0] rem_cur;
    logic [smpr_pkg::DUTY_W-1:0]  duty_sat;
    logic [smpr_pkg::CMP_W-1:0]   tgt_cmd;
    logic [smpr_pkg::CMP_W:0]     cur_hi;
    logic [smpr_pkg::CMP_W:0]     tgt_hi;
    logic                         settled;

    assign ch_idx   = CH_W'(ch_reg);
    assign ch_ok    = (int'(ch_reg) < CHANNELS);
    assign k_cur    = phase_step_reg[ch_idx];
    assign k_inc    = k_cur + 11'd1;
    assign cur_cur  = current_cmp_reg[ch_idx];
    assign tgt_cur  = target_cmp_reg[ch_idx];
    assign rem_cur  = remaining_reg[ch_idx];
    assign duty_sat = (duty_reg > smpr_pkg::DUTY_MAX) ? smpr_pkg::DUTY_MAX : duty_reg;
    assign tgt_cmd  = 10'({3'b000, duty_sat} * smpr_pkg::DUTY_SCALE);
    assign cur_hi   = {1'b0, cur_cur} + 11'(settle_tol_reg);
    assign tgt_hi   = {1'b0, tgt_cur} + 11'(settle_tol_reg);
    assign settled  = (cur_hi >= {1'b0, tgt_cur}) && ({1'b0, cur_cur} <= tgt_hi)
                      && (rem_cur > decel_lead_reg);

    assign mul_prod = 40'(mul_a) * 40'(mul_b);

    always_comb
    begin
        k_mir = k_cur;
        if (cur_cur > tgt_cmd)
        begin
            if (k_cur < smpr_pkg::STEP_HALF)
            begin
                k_mir = smpr_pkg::STEP_FULL - k_cur;
            end
        end
        else if (cur_cur < tgt_cmd)
        begin
            if (k_cur > smpr_pkg::STEP_HALF && k_cur <= smpr_pkg::STEP_FULL)
            begin
                k_mir = smpr_pkg::STEP_FULL - k_cur;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_step_next  = phase_step_reg;
        current_cmp_next = current_cmp_reg;
        target_cmp_next  = target_cmp_reg;
        remaining_next   = remaining_reg;
        pins_next        = pins_reg;
        output_on_next   = output_on_reg;
        ramp_on_next     = ramp_on_reg;
        kind_next        = kind_reg;
        ch_next          = ch_reg;
        duty_next        = duty_reg;
        dir_next         = dir_reg;
        tms_next         = tms_reg;
        kn_next          = kn_reg;
        p_next           = p_reg;
        sq_next          = sq_reg;
        acc_next         = acc_reg;
        div_next         = div_reg;
        q_next           = q_reg;
        mul_a            = '0;
        mul_b            = '0;
        req.ready        = (state_reg == smpr_pkg::ST_IDLE);
        res.valid        = (state_reg == smpr_pkg::ST_OUT);

        unique case (state_reg)
            smpr_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    ch_next    = req.channel;
                    duty_next  = req.duty_percent;
                    dir_next   = req.direction;
                    tms_next   = req.time_ms;
                    state_next = smpr_pkg::ST_EXEC;
                end
            end

            smpr_pkg::ST_EXEC:
            begin
                state_next = smpr_pkg::ST_OUT;
                if (ch_ok)
                begin
                    unique case (kind_reg)
                        smpr_pkg::KIND_COMMAND:
                        begin
                            if (dir_reg == smpr_pkg::DIR_STOP)
                            begin
                                pins_next[ch_idx] = smpr_pkg::PINS_OFF;
                            end
                            else
                            begin
                                remaining_next[ch_idx]  = tms_reg;
                                target_cmp_next[ch_idx] = tgt_cmd;
                                ramp_on_next[ch_idx]    = 1'b1;
                                phase_step_next[ch_idx] = k_mir;
                                output_on_next[ch_idx]  = 1'b1;
                                pins_next[ch_idx] = (dir_reg == smpr_pkg::DIR_CW) ?
                                                    smpr_pkg::PINS_CW : smpr_pkg::PINS_CCW;
                                state_next = smpr_pkg::ST_RAMP;
                            end
                        end
                        smpr_pkg::KIND_PERIOD:
                        begin
                            if (rem_cur == '0)
                            begin
                                pins_next[ch_idx]      = smpr_pkg::PINS_OFF;
                                output_on_next[ch_idx] = 1'b0;
                            end
                            else
                            begin
                                remaining_next[ch_idx] = rem_cur - 15'd1;
                            end
                        end
                        smpr_pkg::KIND_COMPARE:
                        begin
                            if (ramp_on_reg[ch_idx])
                            begin
                                state_next = smpr_pkg::ST_RAMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            smpr_pkg::ST_RAMP:
            begin
                state_next = smpr_pkg::ST_OUT;
                if (rem_cur < decel_lead_reg && k_cur < smpr_pkg::STEP_HALF)
                begin
                    phase_step_next[ch_idx] = smpr_pkg::STEP_FULL - k_cur + 11'd1;
                    ramp_on_next[ch_idx]    = 1'b1;
                end
                else if (settled)
                begin
                    current_cmp_next[ch_idx] = tgt_cur;
                end
                else
                begin
                    kn_next = k_inc;
                    if (k_inc >= smpr_pkg::STEP_LAST)
                    begin
                        phase_step_next[ch_idx] = smpr_pkg::STEP_IDLE;
                        ramp_on_next[ch_idx]    = 1'b0;
                        // A command keeps the pin levels that it set before the ramp step.
                        if (kind_reg != smpr_pkg::KIND_COMMAND)
                        begin
                            pins_next[ch_idx] = smpr_pkg::PINS_OFF;
                        end
                    end
                    else
                    begin
                        phase_step_next[ch_idx] = k_inc;
                    end
                    state_next = smpr_pkg::ST_MUL_P;
                end
            end

            smpr_pkg::ST_MUL_P:
            begin
                mul_a      = 20'(kn_reg);
                mul_b      = 20'(smpr_pkg::STEP_FULL - kn_reg);
                p_next     = mul_prod[smpr_pkg::PROD_W-1:0];
                state_next = smpr_pkg::ST_MUL_SQ;
            end

            smpr_pkg::ST_MUL_SQ:
            begin
                mul_a      = p_reg;
                mul_b      = p_reg;
                sq_next    = mul_prod;
                state_next = smpr_pkg::ST_MUL_LO;
            end

            smpr_pkg::ST_MUL_LO:
            begin
                mul_a      = sq_reg[smpr_pkg::PROD_W-1:0];
                mul_b      = p_reg;
                acc_next   = 60'(mul_prod);
                state_next = smpr_pkg::ST_MUL_HI;
            end

            smpr_pkg::ST_MUL_HI:
            begin
                mul_a      = sq_reg[smpr_pkg::SQ_W-1:smpr_pkg::PROD_W];
                mul_b      = p_reg;
                acc_next   = acc_reg + {mul_prod, 20'd0};
                state_next = smpr_pkg::ST_EST;
            end

            // The estimate is the quotient or one less; q holds the larger candidate.
            smpr_pkg::ST_EST:
            begin
                mul_a      = acc_reg[smpr_pkg::CUBE_W-1:smpr_pkg::CUBE_W-smpr_pkg::PROD_W];
                mul_b      = smpr_pkg::PROFILE_RECIP;
                q_next     = mul_prod[smpr_pkg::PROD_W+smpr_pkg::QUOT_W-1:smpr_pkg::PROD_W]
                             + 10'd1;
                state_next = smpr_pkg::ST_CHK_LO;
            end

            smpr_pkg::ST_CHK_LO:
            begin
                mul_a      = 20'(q_reg);
                mul_b      = smpr_pkg::PROFILE_ODD[smpr_pkg::PROD_W-1:0];
                div_next   = 60'(mul_prod);
                state_next = smpr_pkg::ST_CHK_HI;
            end

            smpr_pkg::ST_CHK_HI:
            begin
                mul_a      = 20'(q_reg);
                mul_b      = 20'(smpr_pkg::PROFILE_ODD[smpr_pkg::ODD_W-1:smpr_pkg::PROD_W]);
                div_next   = div_reg + {mul_prod, 20'd0};
                state_next = smpr_pkg::ST_FINISH;
            end

            smpr_pkg::ST_FINISH:
            begin
                if (kn_reg > smpr_pkg::STEP_FULL)
                begin
                    current_cmp_next[ch_idx] = '0;
                end
                else if (div_reg <= (acc_reg >> smpr_pkg::ODD_SHIFT))
                begin
                    current_cmp_next[ch_idx] = q_reg;
                end
                else
                begin
                    current_cmp_next[ch_idx] = q_reg - 10'd1;
                end
                state_next = smpr_pkg::ST_OUT;
            end

            smpr_pkg::ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = smpr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = smpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.out_channel   = ch_reg;
    assign res.compare_value = ch_ok ? cur_cur : '0;
    assign res.drive_a       = ch_ok ? pins_reg[ch_idx][0] : 1'b0;
    assign res.drive_b       = ch_ok ? pins_reg[ch_idx][1] : 1'b0;
    assign res.pwm_enable    = ch_ok ? output_on_reg[ch_idx] : 1'b0;
    assign res.ramp_running  = ch_ok ? ramp_on_reg[ch_idx] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smpr_pkg::ST_IDLE;
            decel_lead_reg <= smpr_pkg::DECEL_LEAD_RESET;
            settle_tol_reg <= smpr_pkg::SETTLE_TOL_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_step_reg[i]  <= smpr_pkg::STEP_IDLE;
                current_cmp_reg[i] <= '0;
                target_cmp_reg[i]  <= '0;
                remaining_reg[i]   <= '0;
                pins_reg[i]        <= smpr_pkg::PINS_OFF;
                output_on_reg[i]   <= 1'b0;
                ramp_on_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            phase_step_reg  <= phase_step_next;
            current_cmp_reg <= current_cmp_next;
            target_cmp_reg  <= target_cmp_next;
            remaining_reg   <= remaining_next;
            pins_reg        <= pins_next;
            output_on_reg   <= output_on_next;
            ramp_on_reg     <= ramp_on_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    smpr_pkg::REG_DECEL_LEAD:
                    begin
                        decel_lead_reg <= cfg_data;
                    end
                    smpr_pkg::REG_SETTLE_TOL:
                    begin
                        settle_tol_reg <= cfg_data[smpr_pkg::TOL_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        ch_reg   <= ch_next;
        duty_reg <= duty_next;
        dir_reg  <= dir_next;
        tms_reg  <= tms_next;
        kn_reg   <= kn_next;
        p_reg    <= p_next;
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
        div_reg  <= div_next;
        q_reg    <= q_next;
    end

endmodule

`default_nettype wire
